// ===== design/esp_pkg.sv =====
// Shared constants, types and datapath command codes for the encoder speed
// and position estimator. No dependencies; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package esp_pkg;

  // Channel count and field widths
  localparam int CHANNELS   = 4;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int CNT_W      = 16;
  localparam int RPM_W      = 32;
  localparam int POS_W      = 48;
  localparam int SCALE_W    = 24;
  localparam int ALPHA_W    = 17;
  localparam int ALPHA_SH   = 16;

  // Shared multiplier: signed A by signed B
  localparam int MUL_A_W    = RPM_W + 1;
  localparam int MUL_B_W    = SCALE_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_DIR_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_TICK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_PER_TICK = 3'd4;

  // Register reset values
  localparam logic [CHANNELS-1:0] DIR_MASK_RST   = '1;
  localparam logic [SCALE_W-1:0]  RPM_TICK_RST   = 24'd48000;
  localparam logic                FILTER_EN_RST  = 1'b1;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST      = 17'd16384;
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE      = 17'h10000;
  localparam logic [SCALE_W-1:0]  RAD_TICK_RST   = 24'd411775;

  typedef struct packed {
    logic [CHANNELS-1:0] dir_mask;
    logic [SCALE_W-1:0]  rpm_per_tick;
    logic                filter_en;
    logic [ALPHA_W-1:0]  alpha;
    logic [SCALE_W-1:0]  rad_per_tick;
  } cfg_t;

  // Datapath operations, one per controller step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DELTA,
    OP_MUL_RPM,
    OP_SAT_POS,
    OP_MUL_FLT,
    OP_AVG,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [CH_W-1:0] ch;
    logic            last;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== design/esp_in_if.sv =====
// Request channel carrying one sampling tick of raw encoder counters.
// Depends on esp_pkg for the counter width.
`timescale 1ns / 1ps
`default_nettype none

interface esp_in_if
  import esp_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count_ch0;
  logic [CNT_W-1:0] count_ch1;
  logic [CNT_W-1:0] count_ch2;
  logic [CNT_W-1:0] count_ch3;

  modport source (output valid, count_ch0, count_ch1, count_ch2, count_ch3, input ready);
  modport sink   (input valid, count_ch0, count_ch1, count_ch2, count_ch3, output ready);
endinterface

`default_nettype wire

// ===== design/esp_out_if.sv =====
// Result channel carrying one channel's speed and position estimate.
// Depends on esp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface esp_out_if
  import esp_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         channel;
  logic signed [RPM_W-1:0] raw_rpm;
  logic signed [RPM_W-1:0] filtered_rpm;
  logic signed [POS_W-1:0] position;
  logic                    last;

  modport source (output valid, channel, raw_rpm, filtered_rpm, position, last, input ready);
  modport sink   (input valid, channel, raw_rpm, filtered_rpm, position, last, output ready);
endinterface

`default_nettype wire

// ===== design/esp_ctrl.sv =====
// Sequencer for the estimator: walks each channel through the steps of the
// shared multiplier and owns the handshake state. Depends on esp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esp_ctrl
  import esp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_MUL_RPM,
    S_SAT_POS,
    S_MUL_FLT,
    S_AVG,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            last_ch;

  assign last_ch   = (ch_r == CH_W'(CHANNELS - 1));
  assign out_valid = out_valid_r;

  // Next state, commands and handshake
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.ch        = ch_r;
    cmd.last      = last_ch;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          ch_nxt    = '0;
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.op    = OP_DELTA;
        state_nxt = S_MUL_RPM;
      end
      S_MUL_RPM: begin
        cmd.op    = OP_MUL_RPM;
        state_nxt = S_SAT_POS;
      end
      S_SAT_POS: begin
        cmd.op    = OP_SAT_POS;
        state_nxt = S_MUL_FLT;
      end
      S_MUL_FLT: begin
        cmd.op    = OP_MUL_FLT;
        state_nxt = S_AVG;
      end
      S_AVG: begin
        cmd.op    = OP_AVG;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Hold until the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          if (last_ch) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = S_DELTA;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/esp_dp.sv =====
// Datapath of the estimator: per-channel state, one shared signed multiplier
// with a product register, and the result register. Depends on esp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esp_dp
  import esp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_cmd_t                 cmd,
  input  wire cfg_t                    cfg,
  input  wire logic [CNT_W-1:0]        counts [CHANNELS],
  output logic [CH_W-1:0]              out_channel,
  output logic signed [RPM_W-1:0]      out_raw_rpm,
  output logic signed [RPM_W-1:0]      out_filtered_rpm,
  output logic signed [POS_W-1:0]      out_position,
  output logic                         out_last
);

  // Tick counters and per-channel state
  logic [CNT_W-1:0]         cnt_r   [CHANNELS];
  logic [CNT_W-1:0]         prev_r  [CHANNELS];
  logic signed [RPM_W-1:0]  avg_r   [CHANNELS];
  logic [POS_W-1:0]         angle_r [CHANNELS];

  logic signed [CNT_W-1:0]   delta_r;
  logic signed [RPM_W-1:0]   raw_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic [CH_W-1:0]           out_ch_r;
  logic signed [RPM_W-1:0]   out_raw_r;
  logic signed [RPM_W-1:0]   out_filt_r;
  logic signed [POS_W-1:0]   out_pos_r;
  logic                      out_last_r;

  logic [CNT_W-1:0]          oriented;
  logic [CNT_W-1:0]          diff;
  logic [ALPHA_W-1:0]        alpha_cl;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  product;
  logic [PROD_W-RPM_W:0]     prod_hi;
  logic signed [RPM_W-1:0]   raw_sat;
  logic signed [PROD_W-1:0]  prod_shr;
  logic signed [RPM_W-1:0]   avg_sel;

  // Orient the counter and take the wrapped difference
  assign oriented = cfg.dir_mask[cmd.ch] ? cnt_r[cmd.ch] : CNT_W'(0) - cnt_r[cmd.ch];
  assign diff     = oriented - prev_r[cmd.ch];
  assign alpha_cl = cfg.alpha[ALPHA_W-1] ? ALPHA_ONE : cfg.alpha;
  assign avg_sel  = avg_r[cmd.ch];

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = {{(MUL_A_W-CNT_W){delta_r[CNT_W-1]}}, delta_r};
    mul_b = {1'b0, cfg.rpm_per_tick};
    unique case (cmd.op)
      OP_SAT_POS: mul_b = {1'b0, cfg.rad_per_tick};
      OP_MUL_FLT: begin
        mul_a = {raw_r[RPM_W-1], raw_r} - {avg_sel[RPM_W-1], avg_sel};
        mul_b = {{(MUL_B_W-ALPHA_W){1'b0}}, alpha_cl};
      end
      default: ;
    endcase
  end

  assign product = mul_a * mul_b;

  // Saturate the speed product to 32 bits signed
  assign prod_hi = prod_r[PROD_W-1:RPM_W-1];
  always_comb begin
    if ((&prod_hi) || !(|prod_hi)) begin
      raw_sat = prod_r[RPM_W-1:0];
    end else if (prod_r[PROD_W-1]) begin
      raw_sat = {1'b1, {(RPM_W-1){1'b0}}};
    end else begin
      raw_sat = {1'b0, {(RPM_W-1){1'b1}}};
    end
  end

  // Weighted difference scaled back by the alpha fraction, floor rounding
  assign prod_shr = prod_r >>> ALPHA_SH;

  // Per-channel state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_r[i]  <= '0;
        avg_r[i]   <= '0;
        angle_r[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        OP_DELTA:   prev_r[cmd.ch] <= oriented;
        OP_MUL_FLT: angle_r[cmd.ch] <= angle_r[cmd.ch] + prod_r[POS_W-1:0];
        OP_AVG: begin
          if (cfg.filter_en) begin
            avg_r[cmd.ch] <= avg_sel + prod_shr[RPM_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and the result register
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: cnt_r <= counts;
      OP_DELTA:   delta_r <= diff;
      OP_MUL_RPM: prod_r <= product;
      OP_SAT_POS: begin
        raw_r  <= raw_sat;
        prod_r <= product;
      end
      OP_MUL_FLT: prod_r <= product;
      OP_EMIT: begin
        out_ch_r   <= cmd.ch;
        out_raw_r  <= raw_r;
        out_filt_r <= avg_sel;
        out_pos_r  <= angle_r[cmd.ch];
        out_last_r <= cmd.last;
      end
      default: ;
    endcase
  end

  assign out_channel      = out_ch_r;
  assign out_raw_rpm      = out_raw_r;
  assign out_filtered_rpm = out_filt_r;
  assign out_position     = out_pos_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

// ===== design/encoder_speed_position_estimator_top.sv =====
// Top level of the encoder speed and position estimator: configuration registers,
// controller and datapath. Depends on esp_pkg, esp_in_if, esp_out_if, esp_ctrl, esp_dp.
//
// Usage:
//   in_req  : one request per sampling tick with the raw counters of four encoders.
//   out_res : four results per tick, channel 0 first; last marks channel 3.
//   cfg_*   : write-only registers (direction mask, RPM per tick, filter enable,
//             filter alpha, radians per tick), written while the block is idle.
// Flow:
//   Each channel walks through the delta, speed product, saturation and angle
//   product, filter product, average and emit steps, sharing one 33x25 signed
//   multiplier (speed, angle step, filter product). The next request is taken
//   only once the last channel's result has been emitted, so ticks never overlap.
// Stalls:
//   A result waits in the output register; work on the next channel goes on
//   and stops only when its result is ready and the register is still full.
// Reset:
//   rst_n is synchronous, active low. Registers return to their defaults and
//   previous counts, averaged speeds and angles clear to zero.
`timescale 1ns / 1ps
`default_nettype none

module encoder_speed_position_estimator_top
  import esp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  esp_in_if.sink                     in_req,
  esp_out_if.source                  out_res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t             cfg_r;
  dp_cmd_t          cmd;
  logic [CNT_W-1:0] counts [CHANNELS];

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dir_mask     <= DIR_MASK_RST;
      cfg_r.rpm_per_tick <= RPM_TICK_RST;
      cfg_r.filter_en    <= FILTER_EN_RST;
      cfg_r.alpha        <= ALPHA_RST;
      cfg_r.rad_per_tick <= RAD_TICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIR_MASK:     cfg_r.dir_mask     <= cfg_wdata[CHANNELS-1:0];
        REG_RPM_PER_TICK: cfg_r.rpm_per_tick <= cfg_wdata[SCALE_W-1:0];
        REG_FILTER_EN:    cfg_r.filter_en    <= cfg_wdata[0];
        REG_FILTER_ALPHA: cfg_r.alpha        <= cfg_wdata[ALPHA_W-1:0];
        REG_RAD_PER_TICK: cfg_r.rad_per_tick <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the request counters into channel order
  assign counts[0] = in_req.count_ch0;
  assign counts[1] = in_req.count_ch1;
  assign counts[2] = in_req.count_ch2;
  assign counts[3] = in_req.count_ch3;

  esp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .cmd       (cmd)
  );

  esp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg_r),
    .counts           (counts),
    .out_channel      (out_res.channel),
    .out_raw_rpm      (out_res.raw_rpm),
    .out_filtered_rpm (out_res.filtered_rpm),
    .out_position     (out_res.position),
    .out_last         (out_res.last)
  );

endmodule

`default_nettype wire

// ===== design/esp_checker.sv =====
// Port-level checks for the estimator and the bind that attaches them to
// the top level. Depends on esp_pkg and encoder_speed_position_estimator_top.
`timescale 1ns / 1ps
`default_nettype none

module esp_checker
  import esp_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [CH_W-1:0] out_channel,
  input wire logic            out_last
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // Last flag marks the final channel only
  a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_channel == CH_W'(CHANNELS - 1))))
    else $error("last flag on wrong channel");

  // No new request while a tick is in progress
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken twice in a row");

  // Channels still owed block the request side
  a_owed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |-> !in_ready)
    else $error("request side open mid-tick");

  // Reset empties the output
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind encoder_speed_position_estimator_top esp_checker u_esp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_channel (out_res.channel),
  .out_last    (out_res.last)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for encoder_speed_position_estimator_top: a directed
// table, then randomised phases; results checked against table values or an in-bench predictor.
// Depends on esp_pkg, esp_in_if, esp_out_if and the top level of the block.
`timescale 1ns / 1ps

module tb;
  import esp_pkg::*;

  // Unused register indexes, written to show they change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam longint SPEED_MAX   = 64'sd2147483647;
  localparam longint SPEED_MIN   = -64'sd2147483648;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     LONG_HOLD   = 400;
  localparam int     PHASES      = 10;
  localparam int     PHASE_TICKS = 26;
  localparam int     PLAN_LEN    = 33;

  typedef logic [CHANNELS-1:0][CNT_W-1:0] tick_counts_t;

  typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   wdata;
    tick_counts_t            counts;
    bit                      typed;
    logic signed [RPM_W-1:0] raw_rpm;
    logic signed [RPM_W-1:0] filtered_rpm;
    logic signed [POS_W-1:0] position;
  } plan_row_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [RPM_W-1:0] raw_rpm;
    logic signed [RPM_W-1:0] filtered_rpm;
    logic signed [POS_W-1:0] position;
    logic                    last;
  } estimate_t;

  // Directed table: counts are {ch3, ch2, ch1, ch0}
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    // defaults after reset: still, then one tick forward
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h0000}}, 1'b1, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h0001}}, 1'b1, 32'sd48000, 32'sd12000, 48'sd411775},
    // largest forward step, largest backward step, wrap to all ones
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h8000}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h0000}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'hFFFF}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {16'hAAAA, 16'h5555, 16'hFEDC, 16'h1234},
      1'b0, 32'sd0, 32'sd0, 48'sd0},
    // unused indexes, then wide values that mask to all channels negated, filter off
    '{ROW_WRITE, REG_UNUSED_LO, 24'hFFFFFF, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_UNUSED_HI, 24'hFFFFFF, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_DIR_MASK, 24'hFFFFF0, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_FILTER_EN, 24'hFFFFFE, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h0001}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h8001}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000},
      1'b0, 32'sd0, 32'sd0, 48'sd0},
    // top scales, alpha above one, mixed directions: speed saturates both ways
    '{ROW_WRITE, REG_RPM_PER_TICK, 24'hFFFFFF, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_FILTER_ALPHA, 24'hFFFFFF, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_FILTER_EN, 24'h000001, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_RAD_PER_TICK, 24'hFFFFFF, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_DIR_MASK, 24'h000005, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h0000}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h7FFF}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'hFFFF}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h7FFF}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    // bottom scales: speed and angle step vanish
    '{ROW_WRITE, REG_RPM_PER_TICK, 24'h000000, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_FILTER_ALPHA, 24'h000000, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_RAD_PER_TICK, 24'h000000, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_DIR_MASK, 24'h00000F, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h1234}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h4321}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    // alpha exactly one, unit scales
    '{ROW_WRITE, REG_FILTER_ALPHA, 24'h010000, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_RPM_PER_TICK, 24'h000001, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_WRITE, REG_RAD_PER_TICK, 24'h000001, 64'h0, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {4{16'h0000}}, 1'b0, 32'sd0, 32'sd0, 48'sd0},
    '{ROW_TICK, REG_DIR_MASK, 24'h0, {16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001},
      1'b0, 32'sd0, 32'sd0, 48'sd0}
  };

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  esp_in_if  tick_if ();
  esp_out_if est_if ();

  encoder_speed_position_estimator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (tick_if),
    .out_res   (est_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: register shadow and per-channel history
  cfg_t                    shadow_regs;
  logic [CNT_W-1:0]        prev_count [CHANNELS];
  logic signed [RPM_W-1:0] avg_speed  [CHANNELS];
  logic [POS_W-1:0]        angle_acc  [CHANNELS];
  logic [CNT_W-1:0]        sent_count [CHANNELS];

  estimate_t pending_estimates [$];
  int        mismatches;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_requests;
  int        quiet_cycles;

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic signed [RPM_W-1:0] clamp_speed(input longint v);
    if (v > SPEED_MAX) return RPM_W'(SPEED_MAX);
    if (v < SPEED_MIN) return RPM_W'(SPEED_MIN);
    return RPM_W'(v);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DIR_MASK:     shadow_regs.dir_mask     = data[CHANNELS-1:0];
      REG_RPM_PER_TICK: shadow_regs.rpm_per_tick = data[SCALE_W-1:0];
      REG_FILTER_EN:    shadow_regs.filter_en    = data[0];
      REG_FILTER_ALPHA: shadow_regs.alpha        = data[ALPHA_W-1:0];
      REG_RAD_PER_TICK: shadow_regs.rad_per_tick = data[SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  // Work out the four estimates of one tick and queue them
  function automatic void predict_tick(input tick_counts_t counts, input bit typed,
                                       input logic signed [RPM_W-1:0] t_raw,
                                       input logic signed [RPM_W-1:0] t_filt,
                                       input logic signed [POS_W-1:0] t_pos);
    longint                  weight;
    longint                  delta;
    longint                  blend;
    logic [CNT_W-1:0]        oriented;
    logic signed [CNT_W-1:0] step;
    logic signed [RPM_W-1:0] raw;
    estimate_t               est;
    weight = (shadow_regs.alpha > ALPHA_ONE) ? longint'(ALPHA_ONE)
                                             : longint'(shadow_regs.alpha);
    for (int c = 0; c < CHANNELS; c++) begin
      oriented = shadow_regs.dir_mask[c] ? counts[c] : 16'd0 - counts[c];
      step = oriented - prev_count[c];
      delta = step;
      prev_count[c] = oriented;
      raw = clamp_speed(delta * longint'(shadow_regs.rpm_per_tick));
      if (shadow_regs.filter_en) begin
        blend = weight * longint'(raw) +
                (longint'(ALPHA_ONE) - weight) * longint'(avg_speed[c]);
        avg_speed[c] = clamp_speed(blend >>> ALPHA_SH);
      end
      angle_acc[c] = angle_acc[c] + POS_W'(delta * longint'(shadow_regs.rad_per_tick));
      est.channel      = CH_W'(c);
      est.raw_rpm      = typed ? t_raw  : raw;
      est.filtered_rpm = typed ? t_filt : avg_speed[c];
      est.position     = typed ? t_pos  : angle_acc[c];
      est.last         = (c == CHANNELS - 1);
      pending_estimates.push_back(est);
    end
  endfunction

  // Value with random junk above the register width half the time
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                      input int width);
    logic [CFG_DATA_W-1:0] keep;
    keep = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
    if ($urandom_range(1) == 0) return value & keep;
    return (value & keep) | (CFG_DATA_W'($urandom()) & ~keep);
  endfunction

  // Next counters: half-range steps on spin, else mostly plausible motion, some full-range noise
  function automatic tick_counts_t next_counts(input bit spin);
    tick_counts_t counts;
    for (int c = 0; c < CHANNELS; c++) begin
      if (spin) begin
        counts[c] = sent_count[c] + 16'h7FFF;
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: counts[c] = sent_count[c] + CNT_W'($urandom_range(400)) - 16'd200;
          5, 6: counts[c] = sent_count[c] + ($urandom_range(1) ?
                            16'h7FFF - CNT_W'($urandom_range(3)) :
                            16'h8000 + CNT_W'($urandom_range(3)));
          default: counts[c] = CNT_W'($urandom());
        endcase
      end
    end
    return counts;
  endfunction

  // Register write; the write enable drops again before the task returns so writes never overlap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the request line low for a random gap
  task automatic idle_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Offer one tick request and wait until it is taken
  task automatic offer_tick(input tick_counts_t counts, input bit typed,
                            input logic signed [RPM_W-1:0] t_raw,
                            input logic signed [RPM_W-1:0] t_filt,
                            input logic signed [POS_W-1:0] t_pos);
    tick_if.valid     <= 1'b1;
    tick_if.count_ch0 <= counts[0];
    tick_if.count_ch1 <= counts[1];
    tick_if.count_ch2 <= counts[2];
    tick_if.count_ch3 <= counts[3];
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    for (int c = 0; c < CHANNELS; c++) sent_count[c] = counts[c];
    predict_tick(counts, typed, t_raw, t_filt, t_pos);
  endtask

  // Drop the request line and wait for every queued estimate
  task automatic drain_estimates();
    tick_if.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic randomise_settings(input bit spin);
    logic [SCALE_W-1:0] rpm;
    logic [SCALE_W-1:0] rad;
    logic [ALPHA_W-1:0] alpha;
    case ($urandom_range(4))
      0: rpm = '0;
      1: rpm = '1;
      2: rpm = SCALE_W'($urandom());
      default: rpm = SCALE_W'($urandom_range(200000));
    endcase
    case ($urandom_range(3))
      0: rad = '0;
      1: rad = '1;
      default: rad = SCALE_W'($urandom());
    endcase
    case ($urandom_range(4))
      0: alpha = '0;
      1: alpha = ALPHA_ONE;
      2: alpha = ALPHA_W'($urandom_range(17'h1FFFF, 17'h10001));
      default: alpha = ALPHA_W'($urandom_range(17'h10000));
    endcase
    write_reg(REG_DIR_MASK, with_junk(CFG_DATA_W'($urandom_range(15)), CHANNELS));
    write_reg(REG_RPM_PER_TICK, rpm);
    write_reg(REG_FILTER_EN, with_junk(CFG_DATA_W'($urandom_range(3) != 0), 1));
    write_reg(REG_FILTER_ALPHA, with_junk(CFG_DATA_W'(alpha), ALPHA_W));
    write_reg(REG_RAD_PER_TICK, spin ? {SCALE_W{1'b1}} : rad);
    if ($urandom_range(2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                CFG_DATA_W'($urandom()));
  endtask

  function automatic void compare_field(input string field, input logic [CH_W-1:0] ch,
                                        input logic signed [63:0] want,
                                        input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t ns: channel %0d %s mismatch, expected %0d, got %0d",
               $time, ch, field, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random back-pressure, plus long holds on request
  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    est_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        est_if.ready <= 1'b0;
      end else begin
        est_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted estimate with the oldest one queued
  always @(posedge clk) begin : estimate_check
    estimate_t want;
    if (rst_n && est_if.valid && est_if.ready) begin
      if (pending_estimates.size() == 0) begin
        $display("%0t ns: unexpected result on channel %0d", $time, est_if.channel);
        mismatches++;
      end else begin
        want = pending_estimates.pop_front();
        compare_field("channel", want.channel, want.channel, est_if.channel);
        compare_field("raw_rpm", want.channel, want.raw_rpm, est_if.raw_rpm);
        compare_field("filtered_rpm", want.channel, want.filtered_rpm, est_if.filtered_rpm);
        compare_field("position", want.channel, want.position, est_if.position);
        compare_field("last", want.channel, want.last, est_if.last);
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((tick_if.valid && tick_if.ready) || (est_if.valid && est_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    plan_row_t row;
    bit        busy;
    bit        spin;
    mismatches    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    busy          = 1'b0;
    shadow_regs = '{dir_mask: DIR_MASK_RST, rpm_per_tick: RPM_TICK_RST,
                    filter_en: FILTER_EN_RST, alpha: ALPHA_RST,
                    rad_per_tick: RAD_TICK_RST};
    for (int c = 0; c < CHANNELS; c++) begin
      prev_count[c] = '0;
      avg_speed[c]  = '0;
      angle_acc[c]  = '0;
      sent_count[c] = '0;
    end
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_DIR_MASK;
    cfg_wdata         <= '0;
    tick_if.valid     <= 1'b0;
    tick_if.count_ch0 <= '0;
    tick_if.count_ch1 <= '0;
    tick_if.count_ch2 <= '0;
    tick_if.count_ch3 <= '0;
    recv_idle_pct     <= 0;
    hold_requests     <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, back to back with no idling
    for (int i = 0; i < PLAN_LEN; i++) begin
      row = DIRECTED_PLAN[i];
      if (row.kind == ROW_WRITE) begin
        if (busy) drain_estimates();
        busy = 1'b0;
        write_reg(row.idx, row.wdata);
      end else begin
        offer_tick(row.counts, row.typed, row.raw_rpm, row.filtered_rpm, row.position);
        busy = 1'b1;
      end
    end

    // Random phases: new settings while idle, idling pattern rotates
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_estimates();
      case (ph % 3)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct <= 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct <= 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      spin = (ph == 4);
      randomise_settings(spin);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        idle_gap();
        // long result stall while ticks keep coming, so the input backs up
        if (ph == 5 && n == 3) hold_requests <= hold_requests + 1;
        offer_tick(next_counts(spin), 1'b0, 32'sd0, 32'sd0, 48'sd0);
      end
    end

    drain_estimates();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_estimates.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
